>>> rtl/core/tasrr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tasrr_pkg
// Shared types and constants for the three-axis step rate ramp.
// ----------------------------------------------------------------------------
package tasrr_pkg;

   localparam int NUM_AXES = 3;
   localparam int AXIS_W   = 2;
   localparam int RATE_W   = 18;
   localparam int STEP_W   = 17;
   localparam int IVL_W    = 20;
   localparam int TIME_W   = 32;
   localparam int DCNT_W   = 5;

   localparam logic [IVL_W-1:0]  ONE_SECOND_US = 20'd1000000;
   localparam logic [DCNT_W-1:0] DIV_LAST      = 5'd19;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_SET  = 1'b1;

   localparam logic [1:0] CSR_RAMP_PERIOD = 2'd0;
   localparam logic [1:0] CSR_SLOW_STEP   = 2'd1;
   localparam logic [1:0] CSR_FAST_STEP   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RAMP,
      ST_DIV,
      ST_NEXT,
      ST_PULSE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic do_set;
      logic do_tick;
      logic ramp_begin;
      logic ramp_axis;
      logic div_step;
      logic next_axis;
      logic ramp_end;
      logic pulse_eval;
   } cmd_type;

   typedef struct packed {
      logic ramp_due;
      logic mag_zero;
      logic div_last;
      logic last_axis;
   } status_type;

endpackage

>>> rtl/core/tasrr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tasrr_ctrl
// Sequencer for tick and set-target items: ramp, divide, pulse, respond.
// ----------------------------------------------------------------------------
module tasrr_ctrl
   import tasrr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_operation,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_operation == OP_SET) begin
                  cmd.do_set = 1'b1;
                  state_in   = ST_RESP;
               end else begin
                  cmd.do_tick = 1'b1;
                  state_in    = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (status.ramp_due) begin
               cmd.ramp_begin = 1'b1;
               state_in       = ST_RAMP;
            end else begin
               state_in = ST_PULSE;
            end
         end
         ST_RAMP: begin
            cmd.ramp_axis = 1'b1;
            state_in      = status.mag_zero ? ST_NEXT : ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (status.last_axis) begin
               cmd.ramp_end = 1'b1;
               state_in     = ST_PULSE;
            end else begin
               cmd.next_axis = 1'b1;
               state_in      = ST_RAMP;
            end
         end
         ST_PULSE: begin
            cmd.pulse_eval = 1'b1;
            state_in       = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/core/tasrr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tasrr_datapath
// Axis state, time base, ramp arithmetic, shared interval divider.
// ----------------------------------------------------------------------------
module tasrr_datapath
   import tasrr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output status_type               status,
   input  logic                     csr_we,
   input  logic [1:0]               csr_index,
   input  logic [STEP_W-1:0]        csr_wdata,
   input  logic [AXIS_W-1:0]        req_axis,
   input  logic signed [RATE_W-1:0] req_target_rate,
   input  logic                     req_slow_mode,
   input  logic                     req_start_req,
   output logic [NUM_AXES-1:0]      rsp_step_pulses,
   output logic [NUM_AXES-1:0]      rsp_directions,
   output logic                     rsp_moving
);

   logic [15:0]       ramp_period_ff;
   logic [STEP_W-1:0] slow_step_ff, fast_step_ff;

   logic signed [RATE_W-1:0] target_ff [NUM_AXES];
   logic signed [RATE_W-1:0] current_ff [NUM_AXES];
   logic [IVL_W-1:0]         interval_ff [NUM_AXES];
   logic [TIME_W-1:0]        last_step_ff [NUM_AXES];
   logic [TIME_W-1:0]        now_ff, last_ramp_ff;
   logic [NUM_AXES-1:0]      dir_ff, pulses_ff;
   logic                     slow_ff, moving_ff, all_zero_ff;
   logic [AXIS_W-1:0]        axis_ff;

   logic [RATE_W:0]   rem_ff;
   logic [IVL_W-1:0]  dvd_ff, quot_ff;
   logic [RATE_W-1:0] divisor_ff;
   logic [DCNT_W-1:0] dcnt_ff;

   logic signed [RATE_W:0]   cur_x, tgt_x, step_x, sum_x;
   logic signed [RATE_W-1:0] cur_new;
   logic [RATE_W-1:0]        mag;
   logic [RATE_W:0]          rem_sh;
   logic                     q_bit;
   logic [IVL_W-1:0]         quot_in;
   logic [NUM_AXES-1:0]      fire;

   // Ramp move of the selected axis toward its target, clamped at the target.
   always_comb begin
      cur_x  = {current_ff[axis_ff][RATE_W-1], current_ff[axis_ff]};
      tgt_x  = {target_ff[axis_ff][RATE_W-1], target_ff[axis_ff]};
      step_x = {2'b00, (slow_ff ? slow_step_ff : fast_step_ff)};
      sum_x  = cur_x;
      if (cur_x < tgt_x) begin
         sum_x = cur_x + step_x;
         if (sum_x > tgt_x) sum_x = tgt_x;
      end else if (cur_x > tgt_x) begin
         sum_x = cur_x - step_x;
         if (sum_x < tgt_x) sum_x = tgt_x;
      end
      cur_new = sum_x[RATE_W-1:0];
      mag     = cur_new[RATE_W-1] ? (~cur_new + 1'b1) : cur_new;
   end

   // One restoring division step per cycle.
   always_comb begin
      rem_sh  = {rem_ff[RATE_W-1:0], dvd_ff[IVL_W-1]};
      q_bit   = (rem_sh >= {1'b0, divisor_ff});
      quot_in = {quot_ff[IVL_W-2:0], q_bit};
   end

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         fire[a] = moving_ff && (interval_ff[a] != '0) &&
                   ((now_ff - last_step_ff[a]) >= {12'd0, interval_ff[a]});
      end
   end

   always_comb begin
      status.ramp_due  = (now_ff - last_ramp_ff) >= {16'd0, ramp_period_ff};
      status.mag_zero  = (mag == '0);
      status.div_last  = (dcnt_ff == DIV_LAST);
      status.last_axis = (axis_ff == AXIS_W'(NUM_AXES - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_period_ff <= 16'd10000;
         slow_step_ff   <= 17'd40;
         fast_step_ff   <= 17'd10000;
         now_ff         <= '0;
         last_ramp_ff   <= '0;
         dir_ff         <= '0;
         pulses_ff      <= '0;
         slow_ff        <= 1'b0;
         moving_ff      <= 1'b0;
         all_zero_ff    <= 1'b1;
         axis_ff        <= '0;
         for (int a = 0; a < NUM_AXES; a++) begin
            target_ff[a]    <= '0;
            current_ff[a]   <= '0;
            interval_ff[a]  <= '0;
            last_step_ff[a] <= '0;
         end
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_RAMP_PERIOD: ramp_period_ff <= csr_wdata[15:0];
               CSR_SLOW_STEP:   slow_step_ff   <= csr_wdata;
               CSR_FAST_STEP:   fast_step_ff   <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.do_set) begin
            pulses_ff <= '0;
            if (req_axis < AXIS_W'(NUM_AXES)) begin
               target_ff[req_axis] <= req_target_rate;
               slow_ff             <= req_slow_mode;
               if (req_start_req) moving_ff <= 1'b1;
            end
         end
         if (cmd.do_tick) begin
            now_ff <= now_ff + 1'b1;
         end
         if (cmd.ramp_begin) begin
            last_ramp_ff <= now_ff;
            axis_ff      <= '0;
            all_zero_ff  <= 1'b1;
         end
         if (cmd.ramp_axis) begin
            current_ff[axis_ff] <= cur_new;
            if (cur_new != '0) begin
               dir_ff[axis_ff] <= ~cur_new[RATE_W-1];
            end else begin
               interval_ff[axis_ff] <= '0;
            end
            if (cur_new != '0 || target_ff[axis_ff] != '0) all_zero_ff <= 1'b0;
            rem_ff     <= '0;
            dvd_ff     <= ONE_SECOND_US;
            quot_ff    <= '0;
            divisor_ff <= mag;
            dcnt_ff    <= '0;
         end
         if (cmd.div_step) begin
            rem_ff  <= q_bit ? (rem_sh - {1'b0, divisor_ff}) : rem_sh;
            dvd_ff  <= {dvd_ff[IVL_W-2:0], 1'b0};
            quot_ff <= quot_in;
            dcnt_ff <= dcnt_ff + 1'b1;
            if (dcnt_ff == DIV_LAST) interval_ff[axis_ff] <= quot_in;
         end
         if (cmd.next_axis) begin
            axis_ff <= axis_ff + 1'b1;
         end
         if (cmd.ramp_end && all_zero_ff) begin
            moving_ff <= 1'b0;
         end
         if (cmd.pulse_eval) begin
            pulses_ff <= fire;
            for (int a = 0; a < NUM_AXES; a++) begin
               if (fire[a]) last_step_ff[a] <= now_ff;
            end
         end
      end
   end

   assign rsp_step_pulses = pulses_ff;
   assign rsp_directions  = dir_ff;
   assign rsp_moving      = moving_ff;

endmodule

>>> rtl/core/three_axis_step_rate_ramp.sv
`timescale 1ns / 1ps
// A set-target item offers its result in the cycle after the transfer.
// A tick passes through the check, pulse and respond states; on a ramp update each
// axis adds the ramp and next states, plus the shared 20-step divider if its rate
// is nonzero. One item is in flight at a time. Synchronous active-high reset restores
// the register defaults and clears all rates, timers and flags.
// ----------------------------------------------------------------------------
// three_axis_step_rate_ramp
// Velocity ramp and step pulse generator for three stepper axes.
// ----------------------------------------------------------------------------
module three_axis_step_rate_ramp
   import tasrr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_operation,
   input  logic [1:0]               req_axis,
   input  logic signed [17:0]       req_target_rate,
   input  logic                     req_slow_mode,
   input  logic                     req_start_req,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [2:0]               rsp_step_pulses,
   output logic [2:0]               rsp_directions,
   output logic                     rsp_moving,
   input  logic                     csr_we,
   input  logic [1:0]               csr_index,
   input  logic [16:0]              csr_wdata
);

   cmd_type    cmd;
   status_type status;

   tasrr_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .status        (status),
      .cmd           (cmd)
   );

   tasrr_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_axis        (req_axis),
      .req_target_rate (req_target_rate),
      .req_slow_mode   (req_slow_mode),
      .req_start_req   (req_start_req),
      .rsp_step_pulses (rsp_step_pulses),
      .rsp_directions  (rsp_directions),
      .rsp_moving      (rsp_moving)
   );

endmodule

>>> bench/three_axis_step_rate_ramp_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_axis_step_rate_ramp_tb
// Drives set-target and tick items into the step rate ramp with random idle
// gaps on both channels, predicts step pulses, directions and the moving flag
// from an independent model of the ramp, and checks every result transfer.
// ----------------------------------------------------------------------------
module three_axis_step_rate_ramp_tb;
   import tasrr_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE      = 80;

   typedef struct {
      logic [2:0] pulses;
      logic [2:0] dirs;
      logic       mov;
   } step_out_type;

   typedef struct {
      logic              op;
      logic [1:0]        axis;
      logic signed [17:0] rate;
      logic              slow;
      logic              start;
      bit                typed;
      step_out_type      known;
   } stim_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_operation = OP_TICK;
   logic [1:0]        req_axis = '0;
   logic signed [17:0] req_target_rate = '0;
   logic              req_slow_mode = 1'b0;
   logic              req_start_req = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [2:0]        rsp_step_pulses;
   logic [2:0]        rsp_directions;
   logic              rsp_moving;
   logic              csr_we = 1'b0;
   logic [1:0]        csr_index = CSR_RAMP_PERIOD;
   logic [16:0]       csr_wdata = '0;

   step_out_type expected_outputs[$];
   int        failures = 0;
   int        cycles = 0;
   bit        no_idle = 0;
   bit        hold_request = 0;
   int        hold_left = 0;

   // Model state of the ramp.
   logic [31:0] period_us, slow_step, fast_step;
   int          target_hz[NUM_AXES];
   int          rate_hz[NUM_AXES];
   logic [31:0] interval_us[NUM_AXES];
   logic [31:0] last_step_us[NUM_AXES];
   logic [31:0] clock_us, last_ramp_us;
   logic [2:0]  dir_state;
   bit          slow_sel, moving_state;

   three_axis_step_rate_ramp dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic void model_reset();
      period_us = 10000;
      slow_step = 40;
      fast_step = 10000;
      for (int a = 0; a < NUM_AXES; a++) begin
         target_hz[a] = 0;
         rate_hz[a] = 0;
         interval_us[a] = 0;
         last_step_us[a] = 0;
      end
      clock_us = 0;
      last_ramp_us = 0;
      dir_state = '0;
      slow_sel = 0;
      moving_state = 0;
   endfunction

   function automatic void ramp_rates();
      int  step;
      int  cur;
      bit  idle_all;
      step = slow_sel ? int'(slow_step) : int'(fast_step);
      idle_all = 1;
      for (int a = 0; a < NUM_AXES; a++) begin
         cur = rate_hz[a];
         if (cur < target_hz[a]) begin
            cur = cur + step;
            if (cur > target_hz[a]) cur = target_hz[a];
         end else if (cur > target_hz[a]) begin
            cur = cur - step;
            if (cur < target_hz[a]) cur = target_hz[a];
         end
         rate_hz[a] = cur;
         if (cur != 0) begin
            dir_state[a] = (cur > 0);
            interval_us[a] = 32'd1000000 / 32'(cur < 0 ? -cur : cur);
         end else begin
            interval_us[a] = 0;
         end
         if (cur != 0 || target_hz[a] != 0) idle_all = 0;
      end
      if (idle_all) moving_state = 0;
   endfunction

   function automatic step_out_type predict_step_outputs(stim_row_type r);
      step_out_type o;
      o.pulses = '0;
      if (r.op == OP_SET) begin
         if (r.axis < NUM_AXES) begin
            target_hz[r.axis] = int'(r.rate);
            slow_sel = r.slow;
            if (r.start) moving_state = 1;
         end
      end else begin
         clock_us = clock_us + 1;
         if (clock_us - last_ramp_us >= period_us) begin
            last_ramp_us = clock_us;
            ramp_rates();
         end
         for (int a = 0; a < NUM_AXES; a++)
            if (moving_state && interval_us[a] > 0 &&
                clock_us - last_step_us[a] >= interval_us[a]) begin
               last_step_us[a] = clock_us;
               o.pulses[a] = 1'b1;
            end
      end
      o.dirs = dir_state;
      o.mov = moving_state;
      return o;
   endfunction

   // Called at a rising edge; returns at the edge of the transfer or after a gap.
   task automatic send_item(stim_row_type r);
      step_out_type e;
      req_valid <= 1'b1;
      req_operation <= r.op;
      req_axis <= r.axis;
      req_target_rate <= r.rate;
      req_slow_mode <= r.slow;
      req_start_req <= r.start;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      e = predict_step_outputs(r);
      expected_outputs.push_back(r.typed ? r.known : e);
      if (!no_idle && $urandom_range(0, 99) < 19) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      wait (expected_outputs.size() == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [16:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_RAMP_PERIOD: period_us = 32'(value[15:0]);
         CSR_SLOW_STEP:   slow_step = 32'(value);
         CSR_FAST_STEP:   fast_step = 32'(value);
         default: ;
      endcase
   endtask

   function automatic stim_row_type random_row();
      stim_row_type r;
      r.typed = 0;
      r.known = '{default: '0};
      r.op = ($urandom_range(0, 99) < 15) ? OP_SET : OP_TICK;
      r.axis = $urandom_range(0, 3);
      if ($urandom_range(0, 1))
         r.rate = 18'($urandom);
      else
         r.rate = 18'($urandom_range(0, 6000)) * ($urandom_range(0, 1) ? 1 : -1);
      r.slow = $urandom_range(0, 1);
      r.start = ($urandom_range(0, 9) < 8);
      return r;
   endfunction

   function automatic stim_row_type row(logic op, logic [1:0] ax, int rate, logic sl,
                                        logic st, bit typed, logic [2:0] p,
                                        logic [2:0] d, logic m);
      stim_row_type r;
      r.op = op;
      r.axis = ax;
      r.rate = 18'(rate);
      r.slow = sl;
      r.start = st;
      r.typed = typed;
      r.known.pulses = p;
      r.known.dirs = d;
      r.known.mov = m;
      return r;
   endfunction

   // Receiver side: random stalls, one long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_request) begin
         rsp_ready <= 1'b0;
         hold_left <= 300;
         hold_request <= 0;
      end else begin
         rsp_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 19);
      end
   end

   // Outputs are stable at the falling edge; a transfer happens at the next rise.
   always @(negedge clock) begin
      step_out_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_outputs.size() == 0) begin
            $error("result transfer with no expectation waiting");
            failures++;
         end else begin
            e = expected_outputs.pop_front();
            if (rsp_step_pulses !== e.pulses) begin
               $error("step_pulses: expected %0h, got %0h", e.pulses, rsp_step_pulses);
               failures++;
            end
            if (rsp_directions !== e.dirs) begin
               $error("directions: expected %0h, got %0h", e.dirs, rsp_directions);
               failures++;
            end
            if (rsp_moving !== e.mov) begin
               $error("moving: expected %0h, got %0h", e.mov, rsp_moving);
               failures++;
            end
         end
      end
   end

   initial begin
      stim_row_type       directed[$];
      logic [15:0]        periods[6] = '{16'd0, 16'd1, 16'd65535, 16'd3, 16'd7, 16'd2};
      logic [16:0]        slows[6]   = '{17'd0, 17'd131071, 17'd40, 17'd50, 17'd1000, 17'd1};
      logic [16:0]        fasts[6]   = '{17'd0, 17'd1, 17'd10000, 17'd5000, 17'd65536,
                                         17'd131071};
      model_reset();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Defaults: no ramp yet, out-of-range axis ignored, start with zero targets.
      directed.push_back(row(OP_TICK, 0, 0, 0, 0, 1, 0, 0, 0));
      directed.push_back(row(OP_SET, 3, 131071, 1, 1, 1, 0, 0, 0));
      directed.push_back(row(OP_SET, 0, 0, 1, 1, 1, 0, 0, 1));
      // Zero ramp period: the next tick ramps, all zero, so moving drops.
      directed.push_back(row(OP_TICK, 0, 0, 0, 0, 1, 0, 0, 0));
      directed.push_back(row(OP_SET, 0, 131071, 0, 1, 0, 0, 0, 0));
      directed.push_back(row(OP_SET, 1, -131072, 1, 0, 0, 0, 0, 0));
      directed.push_back(row(OP_SET, 2, 1, 0, 0, 0, 0, 0, 0));
      for (int i = 0; i < 8; i++) directed.push_back(row(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(row(OP_SET, 0, -1, 1, 0, 0, 0, 0, 0));
      directed.push_back(row(OP_SET, 1, 0, 0, 0, 0, 0, 0, 0));
      for (int i = 0; i < 6; i++) directed.push_back(row(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0));

      foreach (directed[i]) begin
         if (i == 3) begin
            drain();
            write_csr(CSR_RAMP_PERIOD, 17'd0);
            write_csr(CSR_SLOW_STEP, 17'd65536);
            write_csr(CSR_FAST_STEP, 17'd131071);
         end
         send_item(directed[i]);
      end

      for (int ph = 0; ph < 6; ph++) begin
         drain();
         write_csr(CSR_RAMP_PERIOD, 17'(periods[ph]));
         write_csr(CSR_SLOW_STEP, slows[ph]);
         write_csr(CSR_FAST_STEP, fasts[ph]);
         no_idle = (ph == 3);
         if (ph == 1) hold_request = 1;
         for (int n = 0; n < 100; n++) begin
            // Mid-phase, let every outstanding result arrive before going on.
            if (ph == 4 && n == 50) begin
               req_valid <= 1'b0;
               wait (expected_outputs.size() == 0);
               @(posedge clock);
            end
            send_item(random_row());
         end
      end
      no_idle = 0;

      req_valid <= 1'b0;
      wait (expected_outputs.size() == 0);
      repeat (SETTLE) @(posedge clock);
      if (failures == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
